// ===== src/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg: shared types for the slot pool
// opcodes, status codes, controller states and the controller/datapath bus
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spl_pkg;

    localparam int unsigned SLOTS_DEF      = 16;
    localparam int unsigned OWNER_BITS_DEF = 3;
    localparam int unsigned OPCODE_W       = 3;
    localparam int unsigned STATUS_W       = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC_FIRST = 3'd0,
        OP_ALLOC_SLOT  = 3'd1,
        OP_FREE        = 3'd2,
        OP_FIND        = 3'd3,
        OP_REBUILD     = 3'd4,
        OP_CLEAR       = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BUSY     = 3'd1,
        ST_DISABLED = 3'd2,
        ST_NONE     = 3'd3,
        ST_UNLISTED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_FREE,
        S_APPEND,
        S_FREE_RD,
        S_FREE_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FIND_RD,
        S_FIND_OWN,
        S_FIND_CHK,
        S_REBUILD,
        S_RESULT
    } state_t;

    // list memory write source
    typedef enum logic [1:0] {
        LW_NONE,
        LW_APPEND,
        LW_SHIFT,
        LW_REBUILD
    } list_wr_t;

    // result slot source
    typedef enum logic [1:0] {
        SO_KEEP,
        SO_INPUT,
        SO_INDEX,
        SO_CAND
    } slot_sel_t;

    typedef enum logic [1:0] {
        IX_KEEP,
        IX_ZERO,
        IX_FIND_START,
        IX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CN_KEEP,
        CN_CLEAR,
        CN_INC,
        CN_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        CU_KEEP,
        CU_INDEX,
        CU_COUNT
    } cur_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      clr_res;
        logic      set_status;
        status_t   status;
        slot_sel_t slot_sel;
        cur_sel_t  cur_sel;
        idx_op_t   idx_op;
        cnt_op_t   cnt_op;
        logic      take_slot;
        logic      free_mark;
        logic      clear_pool;
        list_wr_t  list_wr;
        logic      list_rd;
        logic      list_rd_next;
        logic      own_rd;
        logic      cand_load;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    en;
        logic    slot_oor;
        logic    slot_busy;
        logic    cnt_full;
        logic    cnt_zero;
        logic    used_idx;
        logic    idx_last;
        logic    idx_ge_cnt;
        logic    list_hit;
        logic    idx1_lt_cnt;
        logic    idx2_lt_cnt;
        logic    own_match;
        logic    out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/slot_pool_with_active_list.sv =====
// ----------------------------------------------------------------------------
// slot_pool_with_active_list: fixed slot pool with an ordered live list
// allocates, frees and finds slots, keeps the live list compact and in order
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// --------  ---------  -------------------  -----------------------------------
// s_        in         s_tvalid / s_tready  s_tuser opcode, s_tdata operands
// m_        out        m_tvalid / m_tready  m_tuser status, m_tdata results
// cfg_      in         cfg_valid/cfg_ready  cfg_data pool_enabled
//
// one item is worked at a time; after the accept and a dispatch step:
//   alloc first free: scans the in-use marks, then appends and gives the result
//   free: a list read and a compare per entry searched, a read and a write per
//   entry moved down (one list memory read port, registered read), then the result
//   find: a list read, an owner read and a compare per entry visited, then the
//   result
//   rebuild: one pass over the marks, then the result; alloc given slot: append
//   and result; clear, refused allocations and unused opcodes: the result only
// the result goes to an output register; the next item is accepted while it
// waits, and only the final step of that item stalls on a full output
// reset (aresetn low, synchronous) clears marks, owners and count at once;
// the list memory is never cleared and needs no sweep after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slot_pool_with_active_list #(
    parameter int unsigned SLOTS      = spl_pkg::SLOTS_DEF,
    parameter int unsigned OWNER_BITS = spl_pkg::OWNER_BITS_DEF,
    localparam int unsigned SW        = $clog2(SLOTS),
    localparam int unsigned CW        = $clog2(SLOTS + 1),
    localparam int unsigned IN_BITS   = SW + 2 * OWNER_BITS + CW + 2,
    localparam int unsigned S_TDATA_W = ((IN_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_BITS  = SW + 2 * CW,
    localparam int unsigned M_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input item channel
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // slot_number, owner_tag, cursor_in, cursor_start, owner_filter, filter_any
    input  wire logic [S_TDATA_W-1:0]         s_tdata,
    // opcode
    input  wire logic [spl_pkg::OPCODE_W-1:0] s_tuser,
    // result item channel
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // slot_out, cursor_out, live_count
    output logic      [M_TDATA_W-1:0]         m_tdata,
    // status
    output logic      [spl_pkg::STATUS_W-1:0] m_tuser,
    // pool_enabled register write
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_data
);

    // sequencer commands and datapath flags
    spl_pkg::dp_cmd_t  cmd;
    spl_pkg::dp_stat_t stat;

    // controller: one state per step of an opcode
    spl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: marks and owner valid bits in flops, list and owners in ram,
    // walk index, list count, result registers and the output register
    spl_dp #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== src/spl_ram.sv =====
// ----------------------------------------------------------------------------
// spl_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_ram #(
    parameter int unsigned WIDTH = spl_pkg::OWNER_BITS_DEF,
    parameter int unsigned DEPTH = spl_pkg::SLOTS_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/spl_ctrl.sv =====
// ----------------------------------------------------------------------------
// spl_ctrl: slot pool sequencer
// walks each opcode through its steps and drives the datapath commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire spl_pkg::dp_stat_t stat,
    output spl_pkg::dp_cmd_t       cmd
);

    spl_pkg::state_t state_reg;
    spl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spl_pkg::S_IDLE: begin
                if (in_valid) state_next = spl_pkg::S_DISPATCH;
            end
            spl_pkg::S_DISPATCH: begin
                case (stat.op)
                    spl_pkg::OP_ALLOC_FIRST: begin
                        state_next = stat.en ? spl_pkg::S_SCAN_FREE : spl_pkg::S_RESULT;
                    end
                    spl_pkg::OP_ALLOC_SLOT: begin
                        if (!stat.en || stat.slot_oor || stat.slot_busy || stat.cnt_full) begin
                            state_next = spl_pkg::S_RESULT;
                        end else begin
                            state_next = spl_pkg::S_APPEND;
                        end
                    end
                    spl_pkg::OP_FREE: begin
                        if (stat.slot_oor || stat.cnt_zero) begin
                            state_next = spl_pkg::S_RESULT;
                        end else begin
                            state_next = spl_pkg::S_FREE_RD;
                        end
                    end
                    spl_pkg::OP_FIND:    state_next = spl_pkg::S_FIND_RD;
                    spl_pkg::OP_REBUILD: state_next = spl_pkg::S_REBUILD;
                    default:             state_next = spl_pkg::S_RESULT;
                endcase
            end
            spl_pkg::S_SCAN_FREE: begin
                if (!stat.used_idx) begin
                    state_next = stat.cnt_full ? spl_pkg::S_RESULT : spl_pkg::S_APPEND;
                end else if (stat.idx_last) begin
                    state_next = spl_pkg::S_RESULT;
                end
            end
            spl_pkg::S_APPEND:  state_next = spl_pkg::S_RESULT;
            spl_pkg::S_FREE_RD: state_next = spl_pkg::S_FREE_CMP;
            spl_pkg::S_FREE_CMP: begin
                if (!stat.idx1_lt_cnt) begin
                    state_next = spl_pkg::S_RESULT;
                end else if (stat.list_hit) begin
                    state_next = spl_pkg::S_SHIFT_RD;
                end else begin
                    state_next = spl_pkg::S_FREE_RD;
                end
            end
            spl_pkg::S_SHIFT_RD: state_next = spl_pkg::S_SHIFT_WR;
            spl_pkg::S_SHIFT_WR: begin
                state_next = stat.idx2_lt_cnt ? spl_pkg::S_SHIFT_RD : spl_pkg::S_RESULT;
            end
            spl_pkg::S_FIND_RD: begin
                state_next = stat.idx_ge_cnt ? spl_pkg::S_RESULT : spl_pkg::S_FIND_OWN;
            end
            spl_pkg::S_FIND_OWN: state_next = spl_pkg::S_FIND_CHK;
            spl_pkg::S_FIND_CHK: begin
                state_next = stat.own_match ? spl_pkg::S_RESULT : spl_pkg::S_FIND_RD;
            end
            spl_pkg::S_REBUILD: begin
                if (stat.idx_last) state_next = spl_pkg::S_RESULT;
            end
            spl_pkg::S_RESULT: begin
                if (stat.out_free) state_next = spl_pkg::S_IDLE;
            end
            default: state_next = spl_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            spl_pkg::S_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            spl_pkg::S_DISPATCH: begin
                cmd.clr_res = 1'b1;
                case (stat.op)
                    spl_pkg::OP_ALLOC_FIRST: begin
                        if (!stat.en) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = spl_pkg::ST_DISABLED;
                        end else begin
                            cmd.idx_op = spl_pkg::IX_ZERO;
                        end
                    end
                    spl_pkg::OP_ALLOC_SLOT: begin
                        if (!stat.en) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = spl_pkg::ST_DISABLED;
                        end else if (stat.slot_oor || stat.slot_busy || stat.cnt_full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = spl_pkg::ST_BUSY;
                        end else begin
                            cmd.slot_sel = spl_pkg::SO_INPUT;
                        end
                    end
                    spl_pkg::OP_FREE: begin
                        if (stat.slot_oor) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = spl_pkg::ST_UNLISTED;
                        end else begin
                            cmd.free_mark = 1'b1;
                            cmd.slot_sel  = spl_pkg::SO_INPUT;
                            cmd.idx_op    = spl_pkg::IX_ZERO;
                            if (stat.cnt_zero) begin
                                cmd.set_status = 1'b1;
                                cmd.status     = spl_pkg::ST_UNLISTED;
                            end
                        end
                    end
                    spl_pkg::OP_FIND: begin
                        cmd.idx_op = spl_pkg::IX_FIND_START;
                    end
                    spl_pkg::OP_REBUILD: begin
                        cmd.cnt_op = spl_pkg::CN_CLEAR;
                        cmd.idx_op = spl_pkg::IX_ZERO;
                    end
                    spl_pkg::OP_CLEAR: begin
                        cmd.cnt_op     = spl_pkg::CN_CLEAR;
                        cmd.clear_pool = stat.en;
                    end
                    default: ;
                endcase
            end
            spl_pkg::S_SCAN_FREE: begin
                if (!stat.used_idx) begin
                    if (stat.cnt_full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = spl_pkg::ST_BUSY;
                    end else begin
                        cmd.slot_sel = spl_pkg::SO_INDEX;
                    end
                end else if (stat.idx_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = spl_pkg::ST_BUSY;
                end else begin
                    cmd.idx_op = spl_pkg::IX_INC;
                end
            end
            spl_pkg::S_APPEND: begin
                cmd.take_slot = 1'b1;
                cmd.list_wr   = spl_pkg::LW_APPEND;
                cmd.cnt_op    = spl_pkg::CN_INC;
            end
            spl_pkg::S_FREE_RD: begin
                cmd.list_rd = 1'b1;
            end
            spl_pkg::S_FREE_CMP: begin
                if (stat.list_hit) begin
                    if (!stat.idx1_lt_cnt) cmd.cnt_op = spl_pkg::CN_DEC;
                end else if (stat.idx1_lt_cnt) begin
                    cmd.idx_op = spl_pkg::IX_INC;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = spl_pkg::ST_UNLISTED;
                end
            end
            spl_pkg::S_SHIFT_RD: begin
                cmd.list_rd_next = 1'b1;
            end
            spl_pkg::S_SHIFT_WR: begin
                cmd.list_wr = spl_pkg::LW_SHIFT;
                cmd.idx_op  = spl_pkg::IX_INC;
                if (!stat.idx2_lt_cnt) cmd.cnt_op = spl_pkg::CN_DEC;
            end
            spl_pkg::S_FIND_RD: begin
                if (stat.idx_ge_cnt) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = spl_pkg::ST_NONE;
                    cmd.cur_sel    = spl_pkg::CU_COUNT;
                end else begin
                    cmd.list_rd = 1'b1;
                end
            end
            spl_pkg::S_FIND_OWN: begin
                cmd.own_rd    = 1'b1;
                cmd.cand_load = 1'b1;
            end
            spl_pkg::S_FIND_CHK: begin
                if (stat.own_match) begin
                    cmd.slot_sel = spl_pkg::SO_CAND;
                    cmd.cur_sel  = spl_pkg::CU_INDEX;
                end else begin
                    cmd.idx_op = spl_pkg::IX_INC;
                end
            end
            spl_pkg::S_REBUILD: begin
                if (stat.used_idx) begin
                    cmd.list_wr = spl_pkg::LW_REBUILD;
                    cmd.cnt_op  = spl_pkg::CN_INC;
                end
                if (!stat.idx_last) cmd.idx_op = spl_pkg::IX_INC;
            end
            spl_pkg::S_RESULT: begin
                cmd.out_load = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/spl_dp.sv =====
// ----------------------------------------------------------------------------
// spl_dp: slot pool datapath
// marks, owner and list memories, count, walk index, result and output regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_dp #(
    parameter int unsigned SLOTS      = spl_pkg::SLOTS_DEF,
    parameter int unsigned OWNER_BITS = spl_pkg::OWNER_BITS_DEF,
    localparam int unsigned SW        = $clog2(SLOTS),
    localparam int unsigned CW        = $clog2(SLOTS + 1),
    localparam int unsigned IN_BITS   = SW + 2 * OWNER_BITS + CW + 2,
    localparam int unsigned S_TDATA_W = ((IN_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_BITS  = SW + 2 * CW,
    localparam int unsigned M_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [S_TDATA_W-1:0]          s_tdata,
    input  wire logic [spl_pkg::OPCODE_W-1:0]  s_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [M_TDATA_W-1:0]          m_tdata,
    output logic      [spl_pkg::STATUS_W-1:0]  m_tuser,
    input  wire spl_pkg::dp_cmd_t              cmd,
    output spl_pkg::dp_stat_t                  stat
);

    localparam int unsigned O_OWN   = SW;
    localparam int unsigned O_CUR   = O_OWN + OWNER_BITS;
    localparam int unsigned O_START = O_CUR + CW;
    localparam int unsigned O_FILT  = O_START + 1;
    localparam int unsigned O_ANY   = O_FILT + OWNER_BITS;

    // latched item
    spl_pkg::opcode_t      op_reg;
    logic [SW-1:0]         slot_in_reg;
    logic [OWNER_BITS-1:0] owner_in_reg;
    logic [CW-1:0]         cur_in_reg;
    logic                  start_reg;
    logic [OWNER_BITS-1:0] filt_reg;
    logic                  any_reg;

    logic en_reg;

    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] own_valid_reg, own_valid_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [SW-1:0]    cand_reg, cand_next;

    spl_pkg::status_t status_reg, status_next;
    logic [SW-1:0]    slot_out_reg, slot_out_next;
    logic [CW-1:0]    cursor_out_reg, cursor_out_next;

    logic                         m_tvalid_reg;
    logic [SW-1:0]                m_slot_reg;
    logic [CW-1:0]                m_cursor_reg;
    logic [CW-1:0]                m_count_reg;
    logic [spl_pkg::STATUS_W-1:0] m_status_reg;

    logic                  list_wr_en;
    logic [SW-1:0]         list_wr_addr;
    logic [SW-1:0]         list_wr_data;
    logic [SW-1:0]         list_rd_addr;
    logic [SW-1:0]         list_rdata;
    logic [OWNER_BITS-1:0] own_rdata;
    logic [OWNER_BITS-1:0] own_eff;
    logic [CW:0]           idx_p1;
    logic [CW:0]           idx_p2;
    logic [CW-1:0]         find_pos;

    assign idx_p1 = (CW + 1)'(idx_reg) + (CW + 1)'(1);
    assign idx_p2 = (CW + 1)'(idx_reg) + (CW + 1)'(2);

    // first position a find looks at
    assign find_pos = start_reg ? '0 :
                      (cur_in_reg >= cnt_reg) ? cnt_reg : cur_in_reg + CW'(1);

    // an owner entry not written since the last clear reads as zero
    assign own_eff = own_valid_reg[cand_reg] ? own_rdata : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg       <= spl_pkg::opcode_t'(s_tuser);
            slot_in_reg  <= s_tdata[SW-1:0];
            owner_in_reg <= s_tdata[O_OWN +: OWNER_BITS];
            cur_in_reg   <= s_tdata[O_CUR +: CW];
            start_reg    <= s_tdata[O_START];
            filt_reg     <= s_tdata[O_FILT +: OWNER_BITS];
            any_reg      <= s_tdata[O_ANY];
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        used_next       = used_reg;
        own_valid_next  = own_valid_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cand_next       = cand_reg;
        status_next     = status_reg;
        slot_out_next   = slot_out_reg;
        cursor_out_next = cursor_out_reg;

        if (cmd.clr_res) begin
            status_next     = spl_pkg::ST_OK;
            slot_out_next   = '0;
            cursor_out_next = '0;
        end
        if (cmd.set_status) status_next = cmd.status;

        case (cmd.slot_sel)
            spl_pkg::SO_INPUT: slot_out_next = slot_in_reg;
            spl_pkg::SO_INDEX: slot_out_next = idx_reg[SW-1:0];
            spl_pkg::SO_CAND:  slot_out_next = cand_reg;
            default: ;
        endcase

        case (cmd.cur_sel)
            spl_pkg::CU_INDEX: cursor_out_next = idx_reg;
            spl_pkg::CU_COUNT: cursor_out_next = cnt_reg;
            default: ;
        endcase

        case (cmd.idx_op)
            spl_pkg::IX_ZERO:       idx_next = '0;
            spl_pkg::IX_FIND_START: idx_next = find_pos;
            spl_pkg::IX_INC:        idx_next = idx_p1[CW-1:0];
            default: ;
        endcase

        case (cmd.cnt_op)
            spl_pkg::CN_CLEAR: cnt_next = '0;
            spl_pkg::CN_INC:   cnt_next = cnt_reg + CW'(1);
            spl_pkg::CN_DEC:   cnt_next = cnt_reg - CW'(1);
            default: ;
        endcase

        if (cmd.cand_load) cand_next = list_rdata;

        if (cmd.clear_pool) begin
            used_next      = '0;
            own_valid_next = '0;
        end
        if (cmd.free_mark) used_next[slot_in_reg] = 1'b0;
        if (cmd.take_slot) begin
            used_next[slot_out_reg]      = 1'b1;
            own_valid_next[slot_out_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg        <= 1'b0;
            used_reg      <= '0;
            own_valid_reg <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) en_reg <= cfg_data;
            used_reg      <= used_next;
            own_valid_reg <= own_valid_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg       <= cand_next;
        status_reg     <= status_next;
        slot_out_reg   <= slot_out_next;
        cursor_out_reg <= cursor_out_next;
        if (cmd.out_load) begin
            m_slot_reg   <= slot_out_reg;
            m_cursor_reg <= cursor_out_reg;
            m_count_reg  <= cnt_reg;
            m_status_reg <= status_reg;
        end
    end

    // list memory port muxing
    always_comb begin
        list_wr_en   = 1'b1;
        list_wr_addr = cnt_reg[SW-1:0];
        list_wr_data = slot_out_reg;
        case (cmd.list_wr)
            spl_pkg::LW_APPEND: begin
                list_wr_addr = cnt_reg[SW-1:0];
                list_wr_data = slot_out_reg;
            end
            spl_pkg::LW_SHIFT: begin
                list_wr_addr = idx_reg[SW-1:0];
                list_wr_data = list_rdata;
            end
            spl_pkg::LW_REBUILD: begin
                list_wr_addr = cnt_reg[SW-1:0];
                list_wr_data = idx_reg[SW-1:0];
            end
            default: list_wr_en = 1'b0;
        endcase
    end

    assign list_rd_addr = cmd.list_rd_next ? idx_p1[SW-1:0] : idx_reg[SW-1:0];

    spl_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (list_wr_en),
        .wr_addr (list_wr_addr),
        .wr_data (list_wr_data),
        .rd_en   (cmd.list_rd | cmd.list_rd_next),
        .rd_addr (list_rd_addr),
        .rd_data (list_rdata)
    );

    spl_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .aclk    (aclk),
        .wr_en   (cmd.take_slot),
        .wr_addr (slot_out_reg),
        .wr_data (owner_in_reg),
        .rd_en   (cmd.own_rd),
        .rd_addr (list_rdata),
        .rd_data (own_rdata)
    );

    always_comb begin
        stat.op          = op_reg;
        stat.en          = en_reg;
        stat.slot_oor    = CW'(slot_in_reg) >= CW'(SLOTS);
        stat.slot_busy   = !stat.slot_oor && used_reg[slot_in_reg];
        stat.cnt_full    = cnt_reg >= CW'(SLOTS);
        stat.cnt_zero    = cnt_reg == '0;
        stat.used_idx    = used_reg[idx_reg[SW-1:0]];
        stat.idx_last    = idx_reg == CW'(SLOTS - 1);
        stat.idx_ge_cnt  = idx_reg >= cnt_reg;
        stat.list_hit    = list_rdata == slot_in_reg;
        stat.idx1_lt_cnt = idx_p1 < (CW + 1)'(cnt_reg);
        stat.idx2_lt_cnt = idx_p2 < (CW + 1)'(cnt_reg);
        stat.own_match   = any_reg || (own_eff == filt_reg);
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_cursor_reg, m_slot_reg});
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

// ===== src/spl_checker.sv =====
// ----------------------------------------------------------------------------
// spl_checker: port-level checks for the slot pool
// result field consistency, count bound, one item in flight, output hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_checker #(
    parameter int unsigned SLOTS      = spl_pkg::SLOTS_DEF,
    localparam int unsigned SW        = $clog2(SLOTS),
    localparam int unsigned CW        = $clog2(SLOTS + 1),
    localparam int unsigned OUT_BITS  = SW + 2 * CW,
    localparam int unsigned M_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [M_TDATA_W-1:0]         m_tdata,
    input wire logic [spl_pkg::STATUS_W-1:0] m_tuser
);

    logic [SW-1:0] res_slot;
    logic [CW-1:0] res_cursor;
    logic [CW-1:0] res_count;

    assign res_slot   = m_tdata[SW-1:0];
    assign res_cursor = m_tdata[SW +: CW];
    assign res_count  = m_tdata[SW + CW +: CW];

    // live list never holds more than the pool
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_count <= CW'(SLOTS))
        else $error("live count beyond pool size");

    // nothing found reports no slot and the cursor at the list end
    a_none_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == spl_pkg::ST_NONE) |->
            (res_slot == '0) && (res_cursor == res_count))
        else $error("find miss with bad slot or cursor");

    // failed allocation reports zero slot and cursor
    a_fail_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == spl_pkg::ST_BUSY) || (m_tuser == spl_pkg::ST_DISABLED)) |->
            (res_slot == '0) && (res_cursor == '0))
        else $error("failed allocation with nonzero fields");

    // one item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

endmodule

bind slot_pool_with_active_list spl_checker #(.SLOTS(SLOTS)) u_spl_checker (.*);

`default_nettype wire

// ===== tb/sv/slot_pool_with_active_list_tb.sv =====
// ----------------------------------------------------------------------------
// slot_pool_with_active_list_tb: self-checking bench for the slot pool
// a shadow of marks, owners and live list predicts every result item;
// directed corner items, then random phases under varied stall patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_pool_with_active_list_tb;

    localparam int unsigned SLOTS       = spl_pkg::SLOTS_DEF;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned M_TDATA_W   = 16;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 64;

    // opcodes the block leaves unused, still legal on the bus
    localparam logic [spl_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [spl_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    // operand fields, lowest bit first: slot, owner, cursor, start, filter, any
    typedef struct packed {
        logic       filter_any;
        logic [2:0] owner_filter;
        logic       cursor_start;
        logic [4:0] cursor_in;
        logic [2:0] owner_tag;
        logic [3:0] slot_number;
    } operands_t;

    typedef struct packed {
        spl_pkg::status_t status;
        logic [4:0]       live_count;
        logic [4:0]       cursor_out;
        logic [3:0]       slot_out;
    } outcome_t;

    // shadow copy of the pool; predicts the outcome of each accepted item
    class slot_pool_shadow;
        bit        enabled;
        bit        used  [SLOTS];
        bit [2:0]  owner [SLOTS];
        bit [3:0]  live  [SLOTS];
        int        count;
        bit        last_hit;
        bit [4:0]  last_pos;
        bit [2:0]  last_filter;
        bit        last_any;
        int        errors;
        outcome_t  outcomes_due[$];

        function spl_pkg::status_t take(int s, bit [2:0] o);
            if (count >= SLOTS) return spl_pkg::ST_BUSY;
            used[s]     = 1'b1;
            owner[s]    = o;
            live[count] = 4'(s);
            count++;
            return spl_pkg::ST_OK;
        endfunction

        function void note_input(logic [spl_pkg::OPCODE_W-1:0] op, operands_t f);
            outcome_t r;
            int       i;
            int       pos;
            bit       hit;
            r        = '0;
            r.status = spl_pkg::ST_OK;
            case (op)
                spl_pkg::OP_ALLOC_FIRST: begin
                    if (!enabled) begin
                        r.status = spl_pkg::ST_DISABLED;
                    end else begin
                        for (i = 0; i < SLOTS; i++)
                            if (!used[i]) break;
                        if (i >= SLOTS) begin
                            r.status = spl_pkg::ST_BUSY;
                        end else begin
                            r.status = take(i, f.owner_tag);
                            if (r.status == spl_pkg::ST_OK) r.slot_out = 4'(i);
                        end
                    end
                end
                spl_pkg::OP_ALLOC_SLOT: begin
                    if (!enabled) begin
                        r.status = spl_pkg::ST_DISABLED;
                    end else if (used[f.slot_number]) begin
                        r.status = spl_pkg::ST_BUSY;
                    end else begin
                        r.status = take(f.slot_number, f.owner_tag);
                        if (r.status == spl_pkg::ST_OK) r.slot_out = f.slot_number;
                    end
                end
                spl_pkg::OP_FREE: begin
                    used[f.slot_number] = 1'b0;
                    r.slot_out = f.slot_number;
                    for (i = 0; i < count; i++)
                        if (live[i] == f.slot_number) break;
                    if (i >= count) begin
                        r.status = spl_pkg::ST_UNLISTED;
                    end else begin
                        // close the gap, order kept
                        for (; i + 1 < count; i++) live[i] = live[i + 1];
                        count--;
                    end
                end
                spl_pkg::OP_FIND: begin
                    hit = 1'b0;
                    if (f.cursor_start) pos = 0;
                    else if (f.cursor_in >= count) pos = count;
                    else pos = f.cursor_in + 1;
                    for (; pos < count; pos++) begin
                        if (f.filter_any || owner[live[pos]] == f.owner_filter) begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit) begin
                        r.slot_out   = live[pos];
                        r.cursor_out = 5'(pos);
                    end else begin
                        r.status     = spl_pkg::ST_NONE;
                        r.cursor_out = 5'(count);
                    end
                    last_hit    = hit;
                    last_pos    = 5'(pos);
                    last_filter = f.owner_filter;
                    last_any    = f.filter_any;
                end
                spl_pkg::OP_REBUILD: begin
                    count = 0;
                    for (i = 0; i < SLOTS; i++) begin
                        if (used[i]) begin
                            live[count] = 4'(i);
                            count++;
                        end
                    end
                end
                spl_pkg::OP_CLEAR: begin
                    count = 0;
                    if (enabled) begin
                        for (i = 0; i < SLOTS; i++) begin
                            used[i]  = 1'b0;
                            owner[i] = '0;
                        end
                    end
                end
                default: ;
            endcase
            r.live_count = 5'(count);
            outcomes_due.push_back(r);
        endfunction

        function void check_result(logic [spl_pkg::STATUS_W-1:0] st,
                                   logic [M_TDATA_W-1:0] data);
            outcome_t e;
            if (outcomes_due.size() == 0) begin
                $error("result item with nothing due: status %0d data 0x%0h", st, data);
                errors++;
                return;
            end
            e = outcomes_due.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (data[3:0] !== e.slot_out) begin
                $error("slot_out: expected %0d, actual %0d", e.slot_out, data[3:0]);
                errors++;
            end
            if (data[8:4] !== e.cursor_out) begin
                $error("cursor_out: expected %0d, actual %0d", e.cursor_out, data[8:4]);
                errors++;
            end
            if (data[13:9] !== e.live_count) begin
                $error("live_count: expected %0d, actual %0d", e.live_count, data[13:9]);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // slot_number, owner_tag, cursor_in, cursor_start, owner_filter, filter_any
    logic [S_TDATA_W-1:0]           s_tdata   = '0;
    // opcode
    logic [spl_pkg::OPCODE_W-1:0]   s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // slot_out, cursor_out, live_count
    logic [M_TDATA_W-1:0]           m_tdata;
    // status
    logic [spl_pkg::STATUS_W-1:0]   m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_data  = 1'b0;

    slot_pool_shadow shadow;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int cycle_count    = 0;

    slot_pool_with_active_list uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check accepted items, stall at random or for a long hold
    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready) shadow.check_result(m_tuser, m_tdata);
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // offer one item, keep it until taken; valid stays high into the next item
    task automatic send_item(input logic [spl_pkg::OPCODE_W-1:0] op, input operands_t f);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'(f);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        shadow.note_input(op, f);
    endtask

    task automatic issue(input logic [spl_pkg::OPCODE_W-1:0] op, input int slot,
                         input int own, input int cur, input int start, input int filt,
                         input int any);
        operands_t f;
        f.slot_number  = 4'(slot);
        f.owner_tag    = 3'(own);
        f.cursor_in    = 5'(cur);
        f.cursor_start = 1'(start);
        f.owner_filter = 3'(filt);
        f.filter_any   = 1'(any);
        send_item(op, f);
    endtask

    // drop valid and wait for every due result
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (shadow.outcomes_due.size() != 0);
    endtask

    task automatic write_enable(input bit en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow.enabled = en;
    endtask

    // mostly well-formed traffic: frees of live slots, find walks that resume
    // from the last hit, with some noise mixed in
    task automatic random_op();
        int                           r;
        logic [spl_pkg::OPCODE_W-1:0] op;
        operands_t                    f;
        r              = $urandom_range(0, 99);
        f.slot_number  = 4'($urandom_range(0, 15));
        f.owner_tag    = 3'($urandom_range(0, 7));
        f.cursor_in    = 5'($urandom_range(0, 31));
        f.cursor_start = 1'($urandom_range(0, 1));
        f.owner_filter = 3'($urandom_range(0, 7));
        f.filter_any   = 1'($urandom_range(0, 1));
        if (r < 30) begin
            op = spl_pkg::OP_ALLOC_FIRST;
        end else if (r < 42) begin
            op = spl_pkg::OP_ALLOC_SLOT;
        end else if (r < 64) begin
            op = spl_pkg::OP_FREE;
            if (shadow.count > 0 && $urandom_range(0, 9) < 8)
                f.slot_number = shadow.live[$urandom_range(0, shadow.count - 1)];
        end else if (r < 90) begin
            op = spl_pkg::OP_FIND;
            if (shadow.last_hit && $urandom_range(0, 9) < 7) begin
                // resume the walk after the last hit
                f.cursor_start = 1'b0;
                f.cursor_in    = shadow.last_pos;
                f.owner_filter = shadow.last_filter;
                f.filter_any   = shadow.last_any;
            end else if ($urandom_range(0, 9) < 7) begin
                f.cursor_start = 1'b1;
                if (shadow.count > 0)
                    f.owner_filter =
                        shadow.owner[shadow.live[$urandom_range(0, shadow.count - 1)]];
            end
        end else if (r < 94) begin
            op = spl_pkg::OP_REBUILD;
        end else if (r < 97) begin
            op = spl_pkg::OP_CLEAR;
        end else begin
            op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        send_item(op, f);
    endtask

    task automatic run_phase(input bit en, input int src, input int sink, input int n,
                             input bit squeeze);
        settle();
        write_enable(en);
        src_idle_pct   = src;
        sink_stall_pct = sink;
        // long output hold while items keep coming, so the input backs up
        if (squeeze) hold_req = 1'b1;
        repeat (n) random_op();
    endtask

    initial begin
        int i;
        shadow = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pool disabled after reset: alloc refused, free still answers
        issue(spl_pkg::OP_ALLOC_FIRST, 0, 5, 0, 0, 0, 0);
        issue(spl_pkg::OP_FREE, 3, 0, 0, 0, 0, 0);
        settle();
        write_enable(1'b1);

        // top and bottom slots, then a busy named slot
        issue(spl_pkg::OP_ALLOC_SLOT, 15, 7, 0, 0, 0, 0);
        issue(spl_pkg::OP_ALLOC_SLOT, 0, 0, 0, 0, 0, 0);
        issue(spl_pkg::OP_ALLOC_SLOT, 15, 1, 0, 0, 0, 0);
        // fill the list, then one more with no free slot left
        for (i = 0; i < 14; i++) issue(spl_pkg::OP_ALLOC_FIRST, 0, i % 8, 0, 0, 0, 0);
        issue(spl_pkg::OP_ALLOC_FIRST, 0, 3, 0, 0, 0, 0);
        // find from the start, by owner, and with a stale cursor
        issue(spl_pkg::OP_FIND, 0, 0, 0, 1, 0, 1);
        issue(spl_pkg::OP_FIND, 0, 0, 0, 1, 7, 0);
        issue(spl_pkg::OP_FIND, 0, 0, 31, 0, 7, 1);
        // listed free closes the gap, second free of the same slot is unlisted
        issue(spl_pkg::OP_FREE, 0, 0, 0, 0, 0, 0);
        issue(spl_pkg::OP_FREE, 0, 0, 0, 0, 0, 0);
        issue(spl_pkg::OP_REBUILD, 0, 0, 0, 0, 0, 0);
        issue(spl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
        issue(OP_SPARE_6, 15, 7, 31, 1, 7, 1);
        issue(OP_SPARE_7, 15, 7, 31, 1, 7, 1);

        run_phase(1'b1, 0, 0, 250, 1'b0);
        run_phase(1'b1, 87, 0, 150, 1'b0);
        run_phase(1'b0, 0, 87, 100, 1'b0);
        run_phase(1'b1, 28, 28, 250, 1'b0);
        run_phase(1'b1, 0, 0, 150, 1'b1);
        run_phase(1'b0, 28, 28, 150, 1'b0);

        settle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (shadow.errors == 0 && shadow.outcomes_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
